/* rtl/core/mpsc_pkg.sv */
package mpsc_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int TARGET_W = 10;
    localparam int COUNT_W  = 3;
    // Wide enough to hold any store index or the store depth itself.
    localparam int WIDE_W   = 17;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // Answer for a target that lies beyond the store; no real answer uses it.
    localparam logic [COUNT_W-1:0] COUNT_ERROR = 3'd7;
    // Starting value of the running minimum for a new entry.
    localparam logic [COUNT_W-1:0] COUNT_NONE  = 3'd7;
    localparam logic [COUNT_W-1:0] COUNT_ZERO  = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_WRITE,
        ST_READ,
        ST_DELIVER
    } mpsc_state_t;

    typedef struct packed {
        logic start_entry;  // reset the square walk for a new entry
        logic step;         // issue one store read and advance to the next square
        logic accumulate;   // fold the returned store word into the minimum
    } mpsc_fill_ctrl_t;

endpackage

/* rtl/core/mpsc_ram.sv */
module mpsc_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/mpsc_fill_unit.sv */
module mpsc_fill_unit #(
    parameter int TABLE_DEPTH = mpsc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mpsc_pkg::mpsc_fill_ctrl_t        ctrl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   entry_idx,
    input  logic [mpsc_pkg::COUNT_W-1:0]     rd_data,
    output logic                             more,
    output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
    output logic [mpsc_pkg::COUNT_W-1:0]     best
);

    import mpsc_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int SQ_W   = ADDR_W + 1;
    localparam int DIFF_W = ADDR_W + 2;

    logic [ADDR_W-1:0]  j_reg, j_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [COUNT_W-1:0] best_reg, best_next;
    logic [DIFF_W-1:0]  diff;
    logic [COUNT_W:0]   cand;

    // The one subtractor: its borrow tells whether j*j still fits under the entry,
    // and its low bits are the store index to read.
    assign diff    = {2'b00, entry_idx} - {1'b0, sq_reg};
    assign more    = ~diff[DIFF_W-1];
    assign rd_addr = diff[ADDR_W-1:0];
    assign cand    = {1'b0, rd_data} + {{COUNT_W{1'b0}}, 1'b1};
    assign best    = best_reg;

    always_comb begin
        j_next    = j_reg;
        sq_next   = sq_reg;
        best_next = best_reg;
        if (ctrl.start_entry) begin
            j_next    = {{(ADDR_W-1){1'b0}}, 1'b1};
            sq_next   = {{(SQ_W-1){1'b0}}, 1'b1};
            best_next = COUNT_NONE;
        end else begin
            if (ctrl.step) begin
                // (j+1)^2 = j^2 + 2j + 1
                j_next  = j_reg + {{(ADDR_W-1){1'b0}}, 1'b1};
                sq_next = sq_reg + {j_reg, 1'b1};
            end
            if (ctrl.accumulate && (cand < {1'b0, best_reg})) begin
                best_next = cand[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_reg  <= {{(ADDR_W-1){1'b0}}, 1'b1};
            sq_reg <= {{(SQ_W-1){1'b0}}, 1'b1};
        end else begin
            j_reg  <= j_next;
            sq_reg <= sq_next;
        end
        best_reg <= best_next;
    end

endmodule

/* rtl/core/min_perfect_square_count.sv */
// Answers, for each target word n, the least number of perfect squares that
// sum to n (0 for n = 0, otherwise 1 to 4); a target at or beyond TABLE_DEPTH
// returns 7. Answers are kept in a store up to a high-water mark that starts
// at zero after reset. A target below the mark is read out directly and is
// delivered once the output register is free. A target at or past the mark
// first extends the store one entry at a time: for each entry, one shared
// subtract unit walks the squares while the store's single read port returns
// one earlier answer per cycle, followed by a drain step and a write step.
// One word is handled at a time; s_tready is low while a word is being
// worked on, and the result waits in an output register until it is taken.
module min_perfect_square_count #(
    parameter int TABLE_DEPTH = mpsc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mpsc_pkg::S_TDATA_W-1:0]   s_tdata,   // [9:0] target
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mpsc_pkg::M_TDATA_W-1:0]   m_tdata    // [2:0] square_count
);

    import mpsc_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int MARK_W = $clog2(TABLE_DEPTH + 1);

    mpsc_state_t state_reg, state_next;

    logic [MARK_W-1:0]  mark_reg, mark_next;
    logic [ADDR_W-1:0]  tgt_reg, tgt_next;
    logic               err_reg, err_next;
    logic               pend_reg, pend_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [TARGET_W-1:0] s_target;
    logic [WIDE_W-1:0]   tgt_wide;
    logic [WIDE_W-1:0]   mark_wide;
    logic                tgt_oob;
    logic                tgt_stored;
    logic                accept;
    logic                out_free;

    mpsc_fill_ctrl_t    fill_ctrl;
    logic               fill_more;
    logic [ADDR_W-1:0]  fill_addr;
    logic [COUNT_W-1:0] fill_best;
    logic [ADDR_W-1:0]  entry_idx;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [COUNT_W-1:0] ram_rdata;

    assign s_target   = s_tdata[TARGET_W-1:0];
    assign tgt_wide   = WIDE_W'(s_target);
    assign mark_wide  = WIDE_W'(mark_reg);
    assign tgt_oob    = tgt_wide >= WIDE_W'(TABLE_DEPTH);
    assign tgt_stored = tgt_wide < mark_wide;
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign entry_idx  = mark_reg[ADDR_W-1:0];

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (tgt_oob) begin
                        state_next = ST_DELIVER;
                    end else if (tgt_stored) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                if (!fill_more && !pend_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (entry_idx == tgt_reg) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_FILL;
                end
            end
            ST_READ: begin
                state_next = ST_DELIVER;
            end
            ST_DELIVER: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_tready        = 1'b0;
        fill_ctrl       = '0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = fill_addr;
        ram_waddr       = entry_idx;
        ram_wdata       = (mark_reg == '0) ? COUNT_ZERO : fill_best;
        pend_next       = 1'b0;
        mark_next       = mark_reg;
        tgt_next        = tgt_reg;
        err_next        = err_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        count_next      = count_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                fill_ctrl.start_entry = 1'b1;
                if (s_tvalid) begin
                    tgt_next = tgt_wide[ADDR_W-1:0];
                    err_next = tgt_oob;
                end
            end
            ST_FILL: begin
                fill_ctrl.step       = fill_more;
                fill_ctrl.accumulate = pend_reg;
                ram_re               = fill_more;
                pend_next            = fill_more;
            end
            ST_WRITE: begin
                ram_we = 1'b1;
                fill_ctrl.start_entry = 1'b1;
                mark_next = mark_reg + {{(MARK_W-1){1'b0}}, 1'b1};
            end
            ST_READ: begin
                ram_re    = 1'b1;
                ram_raddr = tgt_reg;
            end
            ST_DELIVER: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    count_next    = err_reg ? COUNT_ERROR : ram_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mark_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mark_reg     <= mark_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        tgt_reg   <= tgt_next;
        err_reg   <= err_next;
        count_reg <= count_next;
    end

    mpsc_fill_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_fill (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (fill_ctrl),
        .entry_idx (entry_idx),
        .rd_data   (ram_rdata),
        .more      (fill_more),
        .rd_addr   (fill_addr),
        .best      (fill_best)
    );

    mpsc_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(TABLE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-COUNT_W){1'b0}}, count_reg};

    // A delivered word is either a real answer (0 to 4) or the error code.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (count_reg <= 3'd4 || count_reg == COUNT_ERROR))
        else $error("square count out of range");

    // During a fill, only entries below the one being built are read.
    a_fill_reads_below_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL && fill_more) |-> (WIDE_W'(fill_addr) < mark_wide))
        else $error("fill read reaches an unwritten entry");

    // A target beyond the store goes straight to delivery.
    a_oob_skips_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && tgt_oob) |=> (state_reg == ST_DELIVER && err_reg))
        else $error("out-of-range target touched the store");

    // The mark never passes the store depth.
    a_mark_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        WIDE_W'(mark_reg) <= WIDE_W'(TABLE_DEPTH))
        else $error("high-water mark beyond store depth");

endmodule

/* test/min_perfect_square_count_tb.sv */
module min_perfect_square_count_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpsc_pkg::*;

    localparam int TARGET_MAX     = (1 << TARGET_W) - 1;
    localparam int DIRECTED_WORDS = 23;
    localparam int RANDOM_WORDS   = 77;
    localparam int MAX_REPORTS    = 10;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic                typed;
        logic [COUNT_W-1:0]  answer;
    } square_case_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [COUNT_W-1:0]  answer;
    } pending_answer_t;

    // Answers that can be read off at a glance are typed in; the other rows
    // take their answer from the predictor.
    square_case_t directed_cases [DIRECTED_WORDS] = '{
        '{10'd0,  TYPED,     3'd0},
        '{10'd1,  TYPED,     3'd1},
        '{10'd2,  PREDICTED, 3'd0},
        '{10'd3,  PREDICTED, 3'd0},
        '{10'd4,  TYPED,     3'd1},
        '{10'd0,  TYPED,     3'd0},
        '{10'd7,  TYPED,     3'd4},
        '{10'd5,  PREDICTED, 3'd0},
        '{10'd6,  PREDICTED, 3'd0},
        '{10'd8,  PREDICTED, 3'd0},
        '{10'd9,  TYPED,     3'd1},
        '{10'd12, PREDICTED, 3'd0},
        '{10'd13, PREDICTED, 3'd0},
        '{10'd15, TYPED,     3'd4},
        '{10'd16, TYPED,     3'd1},
        '{10'd23, TYPED,     3'd4},
        '{10'd24, PREDICTED, 3'd0},
        '{10'd28, TYPED,     3'd4},
        '{10'd31, TYPED,     3'd4},
        '{10'd36, TYPED,     3'd1},
        '{10'd10, PREDICTED, 3'd0},
        '{10'd64, TYPED,     3'd1},
        '{10'd60, TYPED,     3'd4}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Private copy of the answer store and its high-water mark.
    logic [COUNT_W-1:0]   answer_store [TABLE_DEPTH_DEF];
    int                   answers_known = 0;

    pending_answer_t      pending_answers [$];
    pending_answer_t      oldest_answer;
    int                   mismatches = 0;
    bit                   send_idle = 1'b0;
    bit                   take_idle = 1'b0;

    min_perfect_square_count i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Extends the store up to the target when needed, then reads the answer.
    function automatic logic [COUNT_W-1:0] predict_square_count(
        input logic [TARGET_W-1:0] target
    );
        int idx;
        int root;
        int best;
        if (int'(target) >= TABLE_DEPTH_DEF)
            return COUNT_ERROR;
        if (int'(target) >= answers_known) begin
            for (idx = answers_known; idx <= int'(target); idx++) begin
                best = (idx == 0) ? int'(COUNT_ZERO) : int'(COUNT_NONE);
                for (root = 1; root * root <= idx; root++) begin
                    if (int'(answer_store[idx - root * root]) + 1 < best)
                        best = int'(answer_store[idx - root * root]) + 1;
                end
                answer_store[idx] = COUNT_W'(best);
            end
            answers_known = int'(target) + 1;
        end
        return answer_store[target];
    endfunction

    task automatic send_target(
        input logic [TARGET_W-1:0] target,
        input logic                typed,
        input logic [COUNT_W-1:0]  typed_answer
    );
        int              gap;
        pending_answer_t entry;
        logic [COUNT_W-1:0] predicted;
        gap = send_idle ? $urandom_range(0, 19) : 0;
        // A valid that stays high for the next word is never lowered first.
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(target);
        do @(posedge aclk); while (!s_tready);
        predicted     = predict_square_count(target);
        entry.target  = target;
        entry.answer  = typed ? typed_answer : predicted;
        pending_answers.push_back(entry);
    endtask

    // Receiver: in randomly chosen runs of 16 words, may lower m_tready before each word.
    initial begin
        int stall;
        int taken;
        taken = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 16 == 0)
                take_idle = ($urandom_range(0, 3) != 0);
            stall = take_idle ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result word 0x%0h arrived with no answer pending", m_tdata);
            end else begin
                oldest_answer = pending_answers.pop_front();
                if (m_tdata !== M_TDATA_W'(oldest_answer.answer)) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("target %0d: square_count expected %0d, got word 0x%0h",
                                 oldest_answer.target, oldest_answer.answer, m_tdata);
                end
            end
        end
    end

    initial begin
        int                  k;
        int                  pick;
        int                  reach;
        logic [TARGET_W-1:0] target;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < DIRECTED_WORDS; k++) begin
            if (k % 8 == 0)
                send_idle = ($urandom_range(0, 3) != 0);
            send_target(directed_cases[k].target, directed_cases[k].typed,
                        directed_cases[k].answer);
        end

        // Half the words push just past the mark so the store keeps growing in
        // short fills; the rest jump anywhere or reread entries already filled.
        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k % 16 == 0)
                send_idle = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (k == RANDOM_WORDS - 1) begin
                target = TARGET_W'(TARGET_MAX);
            end else if (pick < 5 || answers_known == 0) begin
                reach  = answers_known + $urandom_range(0, 31);
                target = TARGET_W'((reach > TARGET_MAX) ? TARGET_MAX : reach);
            end else if (pick < 7) begin
                target = TARGET_W'($urandom);
            end else begin
                target = TARGET_W'($urandom_range(0, answers_known - 1));
            end
            send_target(target, PREDICTED, COUNT_ZERO);
        end
        s_tvalid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* min_perfect_square_count.f */
rtl/core/mpsc_pkg.sv
rtl/core/mpsc_ram.sv
rtl/core/mpsc_fill_unit.sv
rtl/core/min_perfect_square_count.sv
test/min_perfect_square_count_tb.sv
